// ----- rtl/core/fpp_pkg.sv -----
package fpp_pkg;

  localparam int unsigned TUNE_FACTOR_DEF = 4;

  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned XTAL_W   = 26;
  localparam int unsigned DIV_W    = 10;
  localparam int unsigned MULT_W   = 7;
  localparam int unsigned NUM_W    = 20;
  localparam int unsigned WORD_W   = 18;
  localparam int unsigned BOUND_W  = 30;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [XTAL_W-1:0]  XTAL_RESET     = 26'd27000000;
  localparam logic [BOUND_W-1:0] PLL_MIN_HZ     = 30'd405000000;
  localparam logic [BOUND_W-1:0] PLL_MAX_HZ     = 30'd900000000;
  localparam logic [NUM_W-1:0]   FRAC_DENOM     = 20'd1048575;
  localparam int unsigned        PHASED_THRESH  = 3214286;
  localparam logic [BOUND_W-1:0] PHASED_LIMIT   = 30'd126;
  localparam logic [BOUND_W-1:0] PLAIN_LIMIT    = 30'd900;
  localparam logic [WORD_W-1:0]  P1_OFFSET      = 18'd512;
  localparam logic [6:0]         MULT_MIN       = 7'd15;
  localparam logic [6:0]         MULT_MAX       = 7'd90;

  localparam logic [CFG_IDX_W-1:0] REG_XTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_FDIV, S_DMAX, S_DMIN, S_PICK, S_PMUL, S_PDIV, S_NMUL, S_NDIV, S_DONE
  } state_t;

endpackage

// ----- rtl/core/fpp_in_if.sv -----
interface fpp_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpp_pkg::FREQ_W-1:0]    frequency_in;
  logic                          adopt_plan;
  modport source (output valid, frequency_in, adopt_plan, input ready);
  modport sink   (input valid, frequency_in, adopt_plan, output ready);
endinterface

// ----- rtl/core/fpp_out_if.sv -----
interface fpp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          phased_mode;
  logic [fpp_pkg::DIV_W-1:0]     output_divider;
  logic [fpp_pkg::MULT_W-1:0]    pll_multiplier;
  logic [fpp_pkg::NUM_W-1:0]     pll_numerator;
  logic [fpp_pkg::WORD_W-1:0]    pll_word_p1;
  logic [fpp_pkg::NUM_W-1:0]     pll_word_p2;
  logic [fpp_pkg::WORD_W-1:0]    divider_word_p1;
  logic                          divide_by_four_flag;
  logic [7:0]                    clk1_phase_offset;
  modport source (output valid, status, phased_mode, output_divider, pll_multiplier,
                  pll_numerator, pll_word_p1, pll_word_p2, divider_word_p1,
                  divide_by_four_flag, clk1_phase_offset, input ready);
  modport sink   (input valid, status, phased_mode, output_divider, pll_multiplier,
                  pll_numerator, pll_word_p1, pll_word_p2, divider_word_p1,
                  divide_by_four_flag, clk1_phase_offset, output ready);
endinterface

// ----- rtl/core/fpp_cfg_if.sv -----
interface fpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpp_pkg::CFG_IDX_W-1:0]  index;
  logic [fpp_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fractional_pll_frequency_planner_unit.sv -----
// Fractional-N PLL / multisynth frequency planner.
// in_ch:  one item = requested frequency (Hz times TUNE_FACTOR) plus adopt flag.
// out_ch: one result item per input item: status, divider, PLL ratio, packed words.
// cfg_ch: register writes (0 crystal frequency, 1 quadrature enable), always ready;
// write only while no item is in flight.
// Arithmetic runs through one shared restoring divider (1 quotient bit per cycle)
// and one 32x32 multiplier, stepped by a small sequencer. The divide by
// TUNE_FACTOR is a reciprocal multiply, the divide by 1048575 a shift and correct.
// A zero frequency goes straight to a failed result. Otherwise the sequencer works
// out the largest and smallest output divider, then tries the kept divider, the
// largest and the smallest in turn; each one in range is checked on its PLL ratio,
// and for the first that passes the fractional numerator is divided out.
// in_ready is high only while the sequencer idles, so one item is in flight at a
// time; the next item is accepted the cycle after the result is loaded.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the sequencer holds its finished plan until
// the output register frees up, and the input stays stalled meanwhile.
// Reset (synchronous, rst_n low) restores crystal 27 MHz, quadrature on, and
// clears the kept divider and mode.
module fractional_pll_frequency_planner_unit #(
  parameter int unsigned TUNE_FACTOR = fpp_pkg::TUNE_FACTOR_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  fpp_in_if.sink       in_ch,
  fpp_out_if.source    out_ch,
  fpp_cfg_if.sink      cfg_ch
);

  localparam int unsigned QW = 48;   // divider dividend width
  localparam int unsigned DW = 32;   // divisor width
  localparam logic [fpp_pkg::FREQ_W:0] THRESH =
    (fpp_pkg::FREQ_W+1)'(fpp_pkg::PHASED_THRESH * TUNE_FACTOR);
  // f / TUNE_FACTOR = (f * (2^32 + TF_RECIP)) >> (32 + TF_LOG), exact for 32-bit f
  localparam int unsigned TF_LOG = $clog2(TUNE_FACTOR);
  localparam logic [31:0] TF_RECIP =
    32'((((64'd1 << (32 + TF_LOG)) + 64'(TUNE_FACTOR) - 64'd1) / 64'(TUNE_FACTOR))
        - (64'd1 << 32));

  fpp_pkg::state_t state_r, state_nxt;

  logic [fpp_pkg::XTAL_W-1:0] xtal_r;
  logic                       quad_r;
  logic [fpp_pkg::DIV_W-1:0]  cur_div_r;
  logic                       cur_ph_r;

  logic [fpp_pkg::FREQ_W-1:0]  f_r, f_nxt;
  logic                        adopt_r, adopt_nxt;
  logic                        ph_r, ph_nxt;
  logic [fpp_pkg::BOUND_W-1:0] dmax_r, dmax_nxt, dmin_r, dmin_nxt;
  logic [1:0]                  try_r, try_nxt;
  logic [fpp_pkg::DIV_W-1:0]   d_r, d_nxt;
  logic [fpp_pkg::MULT_W-1:0]  mult_r, mult_nxt;
  logic [fpp_pkg::XTAL_W-1:0]  prem_r, prem_nxt;
  logic [fpp_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [6:0]                  fract_r, fract_nxt;
  logic                        fail_r, fail_nxt;

  // shared divider
  logic [QW-1:0]  dq_r;
  logic [DW-1:0]  drem_r, dden_r;
  logic [5:0]     dcnt_r;
  logic           dbusy_r;
  logic           dstart;
  logic [QW-1:0]  dstart_num;
  logic [DW-1:0]  dstart_den;
  logic [5:0]     dstart_n;
  logic [DW:0]    dtrial;

  // shared multiplier
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    mul_p;

  logic           out_valid_r;
  logic           load_out;

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign dtrial = {drem_r, dq_r[QW-1]};

  assign in_ch.ready  = (state_r == fpp_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xtal_r <= fpp_pkg::XTAL_RESET;
      quad_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fpp_pkg::REG_XTAL: xtal_r <= cfg_ch.data[fpp_pkg::XTAL_W-1:0];
        fpp_pkg::REG_QUAD: quad_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (dstart) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= dstart_n;
      dq_r    <= dstart_num << (6'(QW) - dstart_n);
      drem_r  <= '0;
      dden_r  <= dstart_den;
    end else if (dbusy_r) begin
      if (dtrial >= {1'b0, dden_r}) begin
        drem_r <= DW'(dtrial - {1'b0, dden_r});
        dq_r   <= {dq_r[QW-2:0], 1'b1};
      end else begin
        drem_r <= dtrial[DW-1:0];
        dq_r   <= {dq_r[QW-2:0], 1'b0};
      end
      dcnt_r  <= dcnt_r - 6'd1;
      dbusy_r <= (dcnt_r != 6'd1);
    end
  end

  function automatic logic div_ok(input logic [fpp_pkg::BOUND_W-1:0] d);
    div_ok = (d == 30'd4) || (d == 30'd6) || (d >= 30'd8 && d <= fpp_pkg::PLAIN_LIMIT);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpp_pkg::S_IDLE;
      try_r   <= '0;
    end else begin
      state_r <= state_nxt;
      try_r   <= try_nxt;
    end
    f_r <= f_nxt; adopt_r <= adopt_nxt; ph_r <= ph_nxt;
    dmax_r <= dmax_nxt; dmin_r <= dmin_nxt; d_r <= d_nxt;
    mult_r <= mult_nxt; prem_r <= prem_nxt; num_r <= num_nxt;
    fract_r <= fract_nxt; fail_r <= fail_nxt;
  end

  always_comb begin
    logic [fpp_pkg::BOUND_W-1:0] cand, bnd;
    logic                        cand_ok;
    logic [6:0]                  q7;
    logic [67:0]                 fq;
    logic [31:0]                 fdiv;
    logic [26:0]                 fx;
    logic [20:0]                 fr_lo;
    state_nxt = state_r;
    f_nxt = f_r; adopt_nxt = adopt_r; ph_nxt = ph_r;
    dmax_nxt = dmax_r; dmin_nxt = dmin_r; try_nxt = try_r; d_nxt = d_r;
    mult_nxt = mult_r; prem_nxt = prem_r; num_nxt = num_r;
    fract_nxt = fract_r; fail_nxt = fail_r;
    dstart = 1'b0; dstart_num = '0; dstart_den = '0; dstart_n = '0;
    mul_a = f_r; mul_b = {22'd0, d_r};
    load_out = 1'b0;
    cand = '0; cand_ok = 1'b0; bnd = '0;
    q7 = dq_r[6:0];
    fq = '0; fdiv = '0; fx = '0; fr_lo = '0;
    case (state_r)
      fpp_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          adopt_nxt = in_ch.adopt_plan;
          fail_nxt  = 1'b0;
          ph_nxt    = quad_r && ({1'b0, in_ch.frequency_in} > THRESH);
          f_nxt     = in_ch.frequency_in;
          if (ph_nxt) begin
            state_nxt = fpp_pkg::S_FDIV;
          end else if (in_ch.frequency_in == '0) begin
            fail_nxt = 1'b1; state_nxt = fpp_pkg::S_DONE;
          end else begin
            dstart = 1'b1; dstart_num = QW'(fpp_pkg::PLL_MAX_HZ);
            dstart_den = in_ch.frequency_in; dstart_n = 6'd30;
            state_nxt = fpp_pkg::S_DMAX;
          end
        end
      end
      fpp_pkg::S_FDIV: begin
        mul_b = TF_RECIP;
        fq = {4'd0, f_r, 32'd0} + {4'd0, mul_p};
        fdiv = fq[32 + TF_LOG +: 32];
        f_nxt = fdiv;
        if (fdiv == '0) begin
          fail_nxt = 1'b1; state_nxt = fpp_pkg::S_DONE;
        end else begin
          dstart = 1'b1; dstart_num = QW'(fpp_pkg::PLL_MAX_HZ);
          dstart_den = fdiv; dstart_n = 6'd30;
          state_nxt = fpp_pkg::S_DMAX;
        end
      end
      fpp_pkg::S_DMAX: begin
        if (!dbusy_r) begin
          bnd = dq_r[fpp_pkg::BOUND_W-1:0];
          if ((ph_r || bnd < 30'd8) && bnd[0]) bnd = bnd - 30'd1;
          dmax_nxt = bnd;
          dstart = 1'b1; dstart_num = QW'(fpp_pkg::PLL_MIN_HZ);
          dstart_den = f_r; dstart_n = 6'd30;
          state_nxt = fpp_pkg::S_DMIN;
        end
      end
      fpp_pkg::S_DMIN: begin
        if (!dbusy_r) begin
          bnd = dq_r[fpp_pkg::BOUND_W-1:0] + {29'd0, (drem_r != '0)};
          if ((ph_r || bnd < 30'd8) && bnd[0]) bnd = bnd + 30'd1;
          dmin_nxt = bnd;
          try_nxt = 2'd0;
          state_nxt = fpp_pkg::S_PICK;
        end
      end
      fpp_pkg::S_PICK: begin
        case (try_r)
          2'd0: begin
            cand = {20'd0, cur_div_r};
            cand_ok = (cur_ph_r == ph_r) && (cand >= dmin_r) && (cand <= dmax_r);
          end
          2'd1: begin
            cand = dmax_r;
            cand_ok = dmax_r <= (ph_r ? fpp_pkg::PHASED_LIMIT : fpp_pkg::PLAIN_LIMIT);
          end
          2'd2: begin
            cand = dmin_r;
            cand_ok = dmin_r >= 30'd4;
          end
          default: ;
        endcase
        if (try_r == 2'd3) begin
          fail_nxt = 1'b1; state_nxt = fpp_pkg::S_DONE;
        end else if (cand_ok && div_ok(cand) && xtal_r != '0) begin
          d_nxt = cand[fpp_pkg::DIV_W-1:0];
          state_nxt = fpp_pkg::S_PMUL;
        end else begin
          try_nxt = try_r + 2'd1;
        end
      end
      fpp_pkg::S_PMUL: begin
        dstart = 1'b1; dstart_num = mul_p[QW-1:0];
        dstart_den = DW'(xtal_r); dstart_n = 6'd42;
        state_nxt = fpp_pkg::S_PDIV;
      end
      fpp_pkg::S_PDIV: begin
        if (!dbusy_r) begin
          if (dq_r[41:7] != '0 || q7 < fpp_pkg::MULT_MIN || q7 > fpp_pkg::MULT_MAX) begin
            try_nxt = try_r + 2'd1;
            state_nxt = fpp_pkg::S_PICK;
          end else begin
            mult_nxt = q7;
            prem_nxt = drem_r[fpp_pkg::XTAL_W-1:0];
            state_nxt = fpp_pkg::S_NMUL;
          end
        end
      end
      fpp_pkg::S_NMUL: begin
        mul_a = 32'(prem_r); mul_b = {12'd0, fpp_pkg::FRAC_DENOM};
        dstart = 1'b1; dstart_num = mul_p[QW-1:0];
        dstart_den = DW'(xtal_r); dstart_n = 6'd46;
        state_nxt = fpp_pkg::S_NDIV;
      end
      fpp_pkg::S_NDIV: begin
        if (!dbusy_r) begin
          num_nxt = dq_r[fpp_pkg::NUM_W-1:0];
          // x / (2^20 - 1): x = q*2^20 + lo = q*(2^20 - 1) + (lo + q), one correction
          fx = {dq_r[fpp_pkg::NUM_W-1:0], 7'd0};
          fr_lo = {1'b0, fx[19:0]} + {14'd0, fx[26:20]};
          fract_nxt = fx[26:20] + {6'd0, (fr_lo >= {1'b0, fpp_pkg::FRAC_DENOM})};
          state_nxt = fpp_pkg::S_DONE;
        end
      end
      fpp_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out = 1'b1;
          state_nxt = fpp_pkg::S_IDLE;
        end
      end
      default: state_nxt = fpp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_div_r   <= '0;
      cur_ph_r    <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (load_out && !fail_r && adopt_r) begin
        cur_div_r <= d_r;
        cur_ph_r  <= ph_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.status <= fail_r;
      if (fail_r) begin
        out_ch.phased_mode         <= 1'b0;
        out_ch.output_divider      <= '0;
        out_ch.pll_multiplier      <= '0;
        out_ch.pll_numerator       <= '0;
        out_ch.pll_word_p1         <= '0;
        out_ch.pll_word_p2         <= '0;
        out_ch.divider_word_p1     <= '0;
        out_ch.divide_by_four_flag <= 1'b0;
        out_ch.clk1_phase_offset   <= '0;
      end else begin
        out_ch.phased_mode         <= ph_r;
        out_ch.output_divider      <= d_r;
        out_ch.pll_multiplier      <= mult_r;
        out_ch.pll_numerator       <= num_r;
        out_ch.pll_word_p1         <= {4'd0, mult_r, 7'd0} + {11'd0, fract_r}
                                      - fpp_pkg::P1_OFFSET;
        out_ch.pll_word_p2         <= 20'({num_r, 7'd0}
                                      - {7'd0, fpp_pkg::FRAC_DENOM} * {20'd0, fract_r});
        out_ch.divider_word_p1     <= {1'b0, d_r, 7'd0} - fpp_pkg::P1_OFFSET;
        out_ch.divide_by_four_flag <= (d_r == 10'd4);
        out_ch.clk1_phase_offset   <= ph_r ? d_r[7:0] : 8'd0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpp_pkg::S_IDLE) |-> !dbusy_r) else $error("divider busy while idle");
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.status) |-> (out_ch.output_divider >= 10'd4 &&
      out_ch.output_divider <= 10'd900 && out_ch.pll_multiplier >= 7'd15 &&
      out_ch.pll_multiplier <= 7'd90)) else $error("plan out of range");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.status) |-> (out_ch.output_divider == '0 &&
      !out_ch.phased_mode && out_ch.pll_numerator == '0)) else $error("fail fields nonzero");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready)) else $error("result overwritten");
`endif

endmodule
